// ===== rtl/core/aft_pkg.sv =====
// Shared types and constants for the affine point transform.
// Used by every module of the block; depends on nothing.
package aft_pkg;

   localparam int ELEM_W    = 32;
   localparam int REG_W     = 64;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int LANES     = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_X_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_X_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Y_LO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Y_HI = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Z_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Z_HI = 3'd5;

   // Reset values give the identity transform (1.0 is 0x10000 in Q16.16).
   localparam logic [REG_W-1:0] ROW_X_LO_RESET = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] ROW_X_HI_RESET = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] ROW_Y_LO_RESET = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] ROW_Y_HI_RESET = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] ROW_Z_LO_RESET = 64'h0000_0000_0000_0000;
   localparam logic [REG_W-1:0] ROW_Z_HI_RESET = 64'h0000_0000_0001_0000;

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic                     cmd;
      logic signed [ELEM_W-1:0] x_in;
      logic signed [ELEM_W-1:0] y_in;
      logic signed [ELEM_W-1:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] x_out;
      logic signed [ELEM_W-1:0] y_out;
      logic signed [ELEM_W-1:0] z_out;
      logic                     saturated;
   } rsp_type;

   // One matrix row: three coefficients and the translation element.
   typedef struct packed {
      logic signed [ELEM_W-1:0] c0;
      logic signed [ELEM_W-1:0] c1;
      logic signed [ELEM_W-1:0] c2;
      logic signed [ELEM_W-1:0] t;
   } row_type;

   typedef struct packed {
      logic              valid;
      logic [ELEM_W-1:0] value;
      logic              sat;
   } lane_out_type;

endpackage

// ===== rtl/core/aft_lane.sv =====
// One output component: three multiplies, an adder tree and saturation.
// Depends on aft_pkg.
module aft_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  aft_pkg::req_type      req,
   input  aft_pkg::row_type      row,
   output aft_pkg::lane_out_type lane_out
);

   localparam int HI_BIT = aft_pkg::FRAC_BITS + aft_pkg::ELEM_W - 1;

   logic                       valid1_ff, valid2_ff, valid3_ff;
   logic [aft_pkg::PROD_W-1:0] p0_ff, p1_ff, p2_ff, pt_ff;
   logic [aft_pkg::PROD_W-1:0] p0_in, p1_in, p2_in, pt_in;
   logic [aft_pkg::PAIR_W-1:0] sa_ff, sb_ff, sa_in, sb_in;
   logic [aft_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                       fits;

   always_comb begin
      p0_in = $signed(row.c0) * $signed(req.x_in);
      p1_in = $signed(row.c1) * $signed(req.y_in);
      p2_in = $signed(row.c2) * $signed(req.z_in);
      // Translation times w (1.0 if cmd, else 0): a shift into Q32.32.
      if (req.cmd) begin
         pt_in = {{aft_pkg::FRAC_BITS{row.t[aft_pkg::ELEM_W-1]}}, row.t,
                  {aft_pkg::FRAC_BITS{1'b0}}};
      end else begin
         pt_in = '0;
      end
      sa_in  = {p0_ff[aft_pkg::PROD_W-1], p0_ff} + {p1_ff[aft_pkg::PROD_W-1], p1_ff};
      sb_in  = {p2_ff[aft_pkg::PROD_W-1], p2_ff} + {pt_ff[aft_pkg::PROD_W-1], pt_ff};
      sum_in = {sa_ff[aft_pkg::PAIR_W-1], sa_ff} + {sb_ff[aft_pkg::PAIR_W-1], sb_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      pt_ff  <= pt_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      sum_ff <= sum_in;
   end

   // The floored result is sum[SUM_W-1:FRAC_BITS]; it fits in 32 bits when
   // every bit from the result's sign bit upward agrees.
   always_comb begin
      fits = (&sum_ff[aft_pkg::SUM_W-1:HI_BIT]) | ~(|sum_ff[aft_pkg::SUM_W-1:HI_BIT]);
      lane_out.valid = valid3_ff;
      lane_out.sat   = ~fits;
      if (fits) begin
         lane_out.value = sum_ff[HI_BIT:aft_pkg::FRAC_BITS];
      end else if (sum_ff[aft_pkg::SUM_W-1]) begin
         lane_out.value = aft_pkg::SAT_NEG;
      end else begin
         lane_out.value = aft_pkg::SAT_POS;
      end
   end

endmodule

// ===== rtl/core/aft_merge.sv =====
// Merging stage: gathers the three lane results into one registered response.
// Depends on aft_pkg.
module aft_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  aft_pkg::lane_out_type lanes [aft_pkg::LANES],
   output logic                  rsp_valid,
   output aft_pkg::rsp_type      rsp_data
);

   logic             rsp_valid_ff;
   aft_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.x_out     = lanes[0].value;
      rsp_data_in.y_out     = lanes[1].value;
      rsp_data_in.z_out     = lanes[2].value;
      rsp_data_in.saturated = lanes[0].sat | lanes[1].sat | lanes[2].sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lanes[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/affine_point_transform.sv =====
// Top level of the affine point transform: matrix registers, three lanes
// and the merging stage. Depends on aft_pkg, aft_lane and aft_merge.
//
//   channel   ports                                       direction
//   request   start, busy, req_data                       in (busy out)
//   response  rsp_valid, rsp_data                         out
//   csr       csr_valid, csr_ready, csr_index, csr_wdata  in (ready out)
//
// One transaction is accepted every cycle; busy stays low.
// Its response is built in registered steps: multiply, pair add, final add,
// then saturation and merge into the output register.
// Synchronous reset clears the pipeline valids and loads the identity matrix.
// The receiver cannot stall, so the pipeline never holds.
module affine_point_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  aft_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output aft_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aft_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aft_pkg::REG_W-1:0]         csr_wdata
);

   logic [aft_pkg::REG_W-1:0] regs_ff [aft_pkg::NUM_REGS];
   logic [aft_pkg::REG_W-1:0] regs_in [aft_pkg::NUM_REGS];
   logic                      in_valid;
   aft_pkg::row_type          rows  [aft_pkg::LANES];
   aft_pkg::lane_out_type     lanes [aft_pkg::LANES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign in_valid  = start & ~busy;

   always_comb begin
      for (int i = 0; i < aft_pkg::NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            aft_pkg::REG_ROW_X_LO: regs_in[0] = csr_wdata;
            aft_pkg::REG_ROW_X_HI: regs_in[1] = csr_wdata;
            aft_pkg::REG_ROW_Y_LO: regs_in[2] = csr_wdata;
            aft_pkg::REG_ROW_Y_HI: regs_in[3] = csr_wdata;
            aft_pkg::REG_ROW_Z_LO: regs_in[4] = csr_wdata;
            aft_pkg::REG_ROW_Z_HI: regs_in[5] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[0] <= aft_pkg::ROW_X_LO_RESET;
         regs_ff[1] <= aft_pkg::ROW_X_HI_RESET;
         regs_ff[2] <= aft_pkg::ROW_Y_LO_RESET;
         regs_ff[3] <= aft_pkg::ROW_Y_HI_RESET;
         regs_ff[4] <= aft_pkg::ROW_Z_LO_RESET;
         regs_ff[5] <= aft_pkg::ROW_Z_HI_RESET;
      end else begin
         for (int i = 0; i < aft_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   for (genvar k = 0; k < aft_pkg::LANES; k++) begin : g_lane
      assign rows[k].c0 = regs_ff[2*k][aft_pkg::ELEM_W-1:0];
      assign rows[k].c1 = regs_ff[2*k][aft_pkg::REG_W-1:aft_pkg::ELEM_W];
      assign rows[k].c2 = regs_ff[2*k+1][aft_pkg::ELEM_W-1:0];
      assign rows[k].t  = regs_ff[2*k+1][aft_pkg::REG_W-1:aft_pkg::ELEM_W];

      aft_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .in_valid (in_valid),
         .req      (req_data),
         .row      (rows[k]),
         .lane_out (lanes[k])
      );
   end

   aft_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lanes),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/aft_checker.sv =====
// Port-level checks for the affine point transform, bound to the top level.
// Depends on aft_pkg and affine_point_transform.
module aft_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input aft_pkg::rsp_type              rsp_data,
   input logic                          rsp_valid,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   // Every accepted transaction yields a response after a fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted transaction produced no response");

   // No response appears without a matching accepted transaction before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without a matching transaction");

   // A clipped result must carry a saturation value in some component.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.x_out == aft_pkg::SAT_POS || rsp_data.x_out == aft_pkg::SAT_NEG ||
          rsp_data.y_out == aft_pkg::SAT_POS || rsp_data.y_out == aft_pkg::SAT_NEG ||
          rsp_data.z_out == aft_pkg::SAT_POS || rsp_data.z_out == aft_pkg::SAT_NEG))
      else $error("saturated flag set without a clipped component");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("response right after reset");

   // The register port never holds off a write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind affine_point_transform aft_checker u_aft_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
